FILE: hdl/assert_macros.svh
// Concurrent assertion helpers. Expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every clock edge out of reset.
`define FDTW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define FDTW_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hdl/fdtw_pkg.sv
`default_nettype none
package fdtw_pkg;

  localparam int INDEX_BITS_DEF  = 24;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int WORD_W    = 32;
  localparam int DEPTH_W   = 8;
  localparam int CONTENT_W = 24;
  localparam int REF_W     = 32;
  localparam int LEN_W     = 32;
  localparam int KIND_W    = 2;

  localparam logic [WORD_W-1:0] TOK_BEGIN_NODE = 32'd1;
  localparam logic [WORD_W-1:0] TOK_END_NODE   = 32'd2;
  localparam logic [WORD_W-1:0] TOK_PROP       = 32'd3;
  localparam logic [WORD_W-1:0] TOK_NOP        = 32'd4;

  typedef enum logic [2:0] {
    CLS_BEGIN,
    CLS_END_NODE,
    CLS_PROP,
    CLS_NOP,
    CLS_OTHER
  } tok_cls_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NODE   = 2'd0,
    KIND_PROP   = 2'd1,
    KIND_FINISH = 2'd2
  } kind_t;

  // Per-word tags produced by the front end.
  typedef struct packed {
    tok_cls_t cls;
    logic     zero_byte;
    logic     last;
  } fdtw_tag_t;

endpackage
`default_nettype wire

FILE: hdl/fdtw_front.sv
`default_nettype none
module fdtw_front import fdtw_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic [WORD_W-1:0]       in_word,
  input  wire logic                    in_last,
  input  wire logic                    q_full,
  output logic                         in_ready,
  output logic                         push,
  output logic [INDEX_BITS-1:0]        ent_pos,
  output logic [WORD_W-1:0]            ent_word,
  output fdtw_tag_t                    ent_tag
);

  logic [INDEX_BITS-1:0] pos_r;
  logic [INDEX_BITS-1:0] pos_nxt;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign ent_pos  = pos_r;
  assign ent_word = in_word;

  always_comb begin
    ent_tag.last      = in_last;
    ent_tag.zero_byte = (in_word[31:24] == 8'h00) || (in_word[23:16] == 8'h00) ||
                        (in_word[15:8] == 8'h00)  || (in_word[7:0] == 8'h00);
    case (in_word)
      TOK_BEGIN_NODE: ent_tag.cls = CLS_BEGIN;
      TOK_END_NODE:   ent_tag.cls = CLS_END_NODE;
      TOK_PROP:       ent_tag.cls = CLS_PROP;
      TOK_NOP:        ent_tag.cls = CLS_NOP;
      default:        ent_tag.cls = CLS_OTHER;
    endcase
  end

  // word index restarts after the last beat of a block
  assign pos_nxt = in_last ? '0 : pos_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (push) begin
      pos_r <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/fdtw_queue.sv
`default_nettype none
`include "assert_macros.svh"
module fdtw_queue import fdtw_pkg::*; #(
  parameter int WIDTH = 64,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic                  full,
  output logic                  valid,
  output logic [WIDTH-1:0]      rd_data
);

  localparam int PW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `FDTW_ASSERT(a_cnt_bound, (cnt_r <= CNT_W'(DEPTH)), "queue count above depth")
  `FDTW_ASSERT(a_cnt_step, (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1), "missed push")

endmodule
`default_nettype wire

FILE: hdl/fdtw_back.sv
`default_nettype none
`include "assert_macros.svh"
module fdtw_back import fdtw_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  input  wire logic [INDEX_BITS-1:0] ent_pos,
  input  wire logic [WORD_W-1:0]     ent_word,
  input  wire fdtw_tag_t             ent_tag,
  output logic                       pop,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic [KIND_W-1:0]          out_kind,
  output logic [DEPTH_W-1:0]         out_depth,
  output logic [CONTENT_W-1:0]       out_content,
  output logic [REF_W-1:0]           out_ref,
  output logic [LEN_W-1:0]           out_len
);

  typedef enum logic [2:0] {
    PH_ROOT,
    PH_TOKEN,
    PH_NAME,
    PH_PLEN,
    PH_POFF,
    PH_DATA,
    PH_DONE
  } ph_t;

  ph_t                   phase_r, phase_nxt;
  logic [DEPTH_W-1:0]    level_r, level_nxt;
  logic [INDEX_BITS-1:0] name_r, name_nxt;
  logic [LEN_W-1:0]      held_r, held_nxt;
  logic [30:0]           left_r, left_nxt;
  logic [30:0]           left_dec;
  logic [32:0]           len_round;

  logic                  out_valid_r;
  logic [KIND_W-1:0]     kind_r;
  logic [DEPTH_W-1:0]    depth_r;
  logic [CONTENT_W-1:0]  content_r;
  logic [REF_W-1:0]      ref_r;
  logic [LEN_W-1:0]      len_r;

  logic                  out_free;
  logic                  emit;
  kind_t                 e_kind;
  logic [CONTENT_W-1:0]  e_content;
  logic [REF_W-1:0]      e_ref;
  logic [LEN_W-1:0]      e_len;
  logic [INDEX_BITS-1:0] pos1;
  logic [31:0]           pos_ext;
  logic [31:0]           pos1_ext;

  assign out_free = !out_valid_r || out_ready;
  assign pop      = q_valid && out_free;

  assign pos1      = ent_pos + 1'b1;
  assign pos_ext   = 32'(ent_pos);
  assign pos1_ext  = 32'(pos1);
  assign len_round = {1'b0, held_r} + 33'd3;
  assign left_dec  = (left_r != '0) ? left_r - 1'b1 : left_r;

  always_comb begin
    phase_nxt = phase_r;
    level_nxt = level_r;
    name_nxt  = name_r;
    held_nxt  = held_r;
    left_nxt  = left_r;
    emit      = 1'b0;
    e_kind    = KIND_FINISH;
    e_content = pos_ext[CONTENT_W-1:0];
    e_ref     = '0;
    e_len     = '0;
    case (phase_r)
      PH_ROOT: begin
        if (ent_tag.cls == CLS_BEGIN) begin
          level_nxt = '0;
          name_nxt  = pos1;
          phase_nxt = PH_NAME;
        end else if (ent_tag.cls != CLS_NOP) begin
          emit      = 1'b1;
          phase_nxt = PH_DONE;
        end
      end
      PH_TOKEN: begin
        case (ent_tag.cls)
          CLS_NOP: ;
          CLS_BEGIN: begin
            if (level_r == '1) begin
              emit      = 1'b1;
              phase_nxt = PH_DONE;
            end else begin
              name_nxt  = pos1;
              phase_nxt = PH_NAME;
            end
          end
          CLS_END_NODE: begin
            if (level_r == '0) begin
              emit      = 1'b1;
              phase_nxt = PH_DONE;
            end else begin
              level_nxt = level_r - 1'b1;
            end
          end
          CLS_PROP: phase_nxt = PH_PLEN;
          default: begin
            emit      = 1'b1;
            phase_nxt = PH_DONE;
          end
        endcase
      end
      PH_NAME: begin
        if (ent_tag.zero_byte) begin
          emit      = 1'b1;
          e_kind    = KIND_NODE;
          e_content = pos1_ext[CONTENT_W-1:0];
          e_ref     = 32'(name_r);
          level_nxt = level_r + 1'b1;
          phase_nxt = PH_TOKEN;
        end
      end
      PH_PLEN: begin
        held_nxt  = ent_word;
        phase_nxt = PH_POFF;
      end
      PH_POFF: begin
        emit      = 1'b1;
        e_kind    = KIND_PROP;
        e_content = pos1_ext[CONTENT_W-1:0];
        e_ref     = ent_word;
        e_len     = held_r;
        left_nxt  = len_round[32:2];
        phase_nxt = (len_round[32:2] == '0) ? PH_TOKEN : PH_DATA;
      end
      PH_DATA: begin
        left_nxt = left_dec;
        if (left_dec == '0) begin
          phase_nxt = PH_TOKEN;
        end
      end
      default: phase_nxt = PH_DONE;
    endcase
    if (ent_tag.last) begin
      phase_nxt = PH_ROOT;
      level_nxt = '0;
      name_nxt  = '0;
      held_nxt  = '0;
      left_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_ROOT;
      level_r     <= '0;
      name_r      <= '0;
      held_r      <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r <= phase_nxt;
        level_r <= level_nxt;
        name_r  <= name_nxt;
        held_r  <= held_nxt;
        left_r  <= left_nxt;
      end
      if (out_free) begin
        out_valid_r <= pop && emit;
      end
      if (pop && emit) begin
        kind_r    <= e_kind;
        depth_r   <= level_r;
        content_r <= e_content;
        ref_r     <= e_ref;
        len_r     <= e_len;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = kind_r;
  assign out_depth   = depth_r;
  assign out_content = content_r;
  assign out_ref     = ref_r;
  assign out_len     = len_r;

  `FDTW_ASSERT(a_last_idle, (pop && ent_tag.last) |=> (phase_r == PH_ROOT), "idle after last")
  `FDTW_ASSERT_IMPLY(a_done_silent, (pop && (phase_r == PH_DONE)), !emit, "event after finish")

endmodule
`default_nettype wire

FILE: hdl/fdt_structure_walker.sv
// Device-tree structure block walker.
// Input stream: one 32-bit structure word per beat on in_tdata (byte order
// already converted), in_tlast on the final word of a block. The walker emits
// one event beat per node (kind 0), property (kind 1) or finish (kind 2) on
// the out_ channel, a node's on its last name word and a property's on its
// offset word; NOPs, other name words, length words and property data give none.
// Each event is loaded into the output register as the queue entry of the word
// that causes it is popped. Throughput: one word per cycle while the receiver
// keeps up; the back end updates its state for each popped word.
// A front end tags each word (token class, zero-byte flag, word index) and
// writes it to a QUEUE_DEPTH entry queue; the back end runs the parse state
// machine and loads the output register. When the receiver stalls, the
// back end holds, the queue fills, and in_tready drops once it is full.
// Reset (synchronous, rst_n low) empties the queue, clears the word index and
// puts the walker in its wait-for-root state; no clearing pass is needed.
// After a finish event further words are dropped until a tlast beat.
`default_nettype none
module fdt_structure_walker import fdtw_pkg::*; #(
  parameter int INDEX_BITS  = INDEX_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [31:0]  in_tdata,   // [31:0] word
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [95:0]       out_tdata,  // [7:0] depth, [31:8] content_index,
                                        // [63:32] name_ref, [95:64] value_length
  output logic [1:0]        out_tuser   // [1:0] kind
);

  localparam int ENT_W = INDEX_BITS + WORD_W + $bits(fdtw_tag_t);

  logic                  q_full;
  logic                  q_valid;
  logic                  push;
  logic                  pop;
  logic [INDEX_BITS-1:0] f_pos;
  logic [WORD_W-1:0]     f_word;
  fdtw_tag_t             f_tag;
  logic [ENT_W-1:0]      q_wr;
  logic [ENT_W-1:0]      q_rd;
  logic [INDEX_BITS-1:0] b_pos;
  logic [WORD_W-1:0]     b_word;
  fdtw_tag_t             b_tag;
  logic [DEPTH_W-1:0]    o_depth;
  logic [CONTENT_W-1:0]  o_content;
  logic [REF_W-1:0]      o_ref;
  logic [LEN_W-1:0]      o_len;

  fdtw_front #(
    .INDEX_BITS(INDEX_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_word  (in_tdata),
    .in_last  (in_tlast),
    .q_full   (q_full),
    .in_ready (in_tready),
    .push     (push),
    .ent_pos  (f_pos),
    .ent_word (f_word),
    .ent_tag  (f_tag)
  );

  assign q_wr = {f_pos, f_word, f_tag};

  fdtw_queue #(
    .WIDTH(ENT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (q_wr),
    .pop     (pop),
    .full    (q_full),
    .valid   (q_valid),
    .rd_data (q_rd)
  );

  assign {b_pos, b_word, b_tag} = q_rd;

  fdtw_back #(
    .INDEX_BITS(INDEX_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .ent_pos     (b_pos),
    .ent_word    (b_word),
    .ent_tag     (b_tag),
    .pop         (pop),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_kind    (out_tuser),
    .out_depth   (o_depth),
    .out_content (o_content),
    .out_ref     (o_ref),
    .out_len     (o_len)
  );

  assign out_tdata = {o_len, o_ref, o_content, o_depth};

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fdtw_pkg::*;

  localparam int ITEMS        = 1250;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 8;
  localparam int N_ROWS       = 25;
  localparam logic [31:0] TOK_END = 32'd9;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  depth;
    logic [23:0] content;
    logic [31:0] nref;
    logic [31:0] vlen;
  } fdt_event_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } struct_word_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic        typed;
    fdt_event_t  ev;
  } dir_row_t;

  typedef enum logic [2:0] {
    WP_ROOT, WP_TOKEN, WP_NAME, WP_PLEN, WP_POFF, WP_DATA, WP_DONE
  } walk_phase_t;

  localparam fdt_event_t NO_EVENT = '0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic [1:0]  out_tuser;

  fdt_structure_walker uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // walker shadow state
  walk_phase_t phase = WP_ROOT;
  logic [7:0]  level = '0;
  logic [23:0] wpos = '0;
  logic [23:0] name_at = '0;
  logic [31:0] held_len = '0;
  logic [30:0] data_left = '0;

  fdt_event_t   pending_events[$];
  struct_word_t walk_q[$];
  dir_row_t     dir_rows [N_ROWS];
  fdt_event_t   seen_ev, want_ev;
  int           fails = 0;
  int           walk_items = 0;
  int           stall_cycles = 0;
  bit           calm = 1'b0;
  bit           deep_done = 1'b0;

  function void reset_walker();
    phase = WP_ROOT;
    level = '0;
    wpos = '0;
    name_at = '0;
    held_len = '0;
    data_left = '0;
  endfunction

  function fdt_event_t finish_event();
    phase = WP_DONE;
    return '{KIND_FINISH, level, wpos, 32'd0, 32'd0};
  endfunction

  function bit walk_word(input logic [31:0] w, input logic l, output fdt_event_t ev);
    bit hit;
    bit zero_byte;
    hit = 1'b0;
    ev = NO_EVENT;
    zero_byte = (w[31:24] == 8'd0) || (w[23:16] == 8'd0) ||
                (w[15:8] == 8'd0) || (w[7:0] == 8'd0);
    case (phase)
      WP_ROOT: begin
        if (w == TOK_BEGIN_NODE) begin
          level = '0;
          name_at = wpos + 24'd1;
          phase = WP_NAME;
        end else if (w != TOK_NOP) begin
          ev = finish_event();
          hit = 1'b1;
        end
      end
      WP_TOKEN: begin
        if (w == TOK_NOP) begin
        end else if (w == TOK_BEGIN_NODE) begin
          if (level == 8'd255) begin
            ev = finish_event();
            hit = 1'b1;
          end else begin
            name_at = wpos + 24'd1;
            phase = WP_NAME;
          end
        end else if (w == TOK_END_NODE) begin
          if (level == 8'd0) begin
            ev = finish_event();
            hit = 1'b1;
          end else begin
            level = level - 8'd1;
          end
        end else if (w == TOK_PROP) begin
          phase = WP_PLEN;
        end else begin
          ev = finish_event();
          hit = 1'b1;
        end
      end
      WP_NAME: begin
        if (zero_byte) begin
          ev = '{KIND_NODE, level, wpos + 24'd1, {8'd0, name_at}, 32'd0};
          hit = 1'b1;
          level = level + 8'd1;
          phase = WP_TOKEN;
        end
      end
      WP_PLEN: begin
        held_len = w;
        phase = WP_POFF;
      end
      WP_POFF: begin
        ev = '{KIND_PROP, level, wpos + 24'd1, w, held_len};
        hit = 1'b1;
        data_left = 31'((33'(held_len) + 33'd3) >> 2);
        phase = (data_left == '0) ? WP_TOKEN : WP_DATA;
      end
      WP_DATA: begin
        if (data_left != '0) data_left = data_left - 31'd1;
        if (data_left == '0) phase = WP_TOKEN;
      end
      default: phase = WP_DONE;
    endcase
    wpos = wpos + 24'd1;
    if (l) reset_walker();
    return hit;
  endfunction

  // stream generation
  function void add(input logic [31:0] w, input logic l = 1'b0);
    walk_q.push_back('{w, l});
  endfunction

  function logic [31:0] name_word(input bit term);
    logic [31:0] w;
    int k;
    w = $urandom;
    k = $urandom_range(0, 3);
    if (term) w[8*k +: 8] = 8'd0;
    else w = w | 32'h0101_0101;
    return w;
  endfunction

  function void add_name();
    repeat ($urandom_range(0, 2)) add(name_word(1'b0));
    add(name_word(1'b1));
  endfunction

  function void add_prop();
    int r;
    logic [31:0] len;
    r = $urandom_range(0, 99);
    len = (r < 10) ? 32'd0 : (r < 85) ? $urandom_range(1, 12) : $urandom_range(13, 64);
    add(TOK_PROP);
    add(len);
    add($urandom);
    repeat ((len + 3) / 4) add($urandom);
  endfunction

  function void gen_walk();
    int lvl;
    int r;
    int k;
    repeat ($urandom_range(0, 2)) add(TOK_NOP);
    add(TOK_BEGIN_NODE);
    add_name();
    lvl = 1;
    repeat ($urandom_range(2, 20)) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        add_prop();
      end else if (r < 60 && lvl < 8) begin
        add(TOK_BEGIN_NODE);
        add_name();
        lvl++;
      end else if (r < 80 && lvl > 1) begin
        add(TOK_END_NODE);
        lvl--;
      end else if (r < 97) begin
        add(TOK_NOP);
      end else begin
        add($urandom);
      end
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      // huge property, cut short by the block end
      add(TOK_PROP);
      add($urandom | 32'h8000_0000);
      add($urandom);
      repeat ($urandom_range(0, 3)) add($urandom);
      add($urandom, 1'b1);
      return;
    end
    repeat (lvl) add(TOK_END_NODE);
    if (r < 70) begin
      add(TOK_END, 1'b1);
    end else if (r < 82) begin
      add(TOK_END);
      repeat ($urandom_range(0, 2)) add($urandom);
      add($urandom, 1'b1);
    end else if (r < 90) begin
      add(TOK_END_NODE);
      add(TOK_NOP);
      add(TOK_BEGIN_NODE, 1'b1);
    end else begin
      k = $urandom_range(0, walk_q.size() - 1);
      walk_q[k].last = 1'b1;
      while (walk_q.size() > k + 1) void'(walk_q.pop_back());
    end
  endfunction

  function void add_noise();
    logic [31:0] w;
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 5))
        0: w = TOK_BEGIN_NODE;
        1: w = TOK_END_NODE;
        2: w = TOK_PROP;
        3: w = TOK_NOP;
        4: w = TOK_END;
        default: w = $urandom;
      endcase
      add(w, $urandom_range(0, 7) == 0);
    end
    add($urandom, 1'b1);
  endfunction

  // nest to level 255, a property at depth 255, then one BEGIN_NODE too many
  function void add_deep_walk();
    add(TOK_BEGIN_NODE);
    add(32'h0);
    repeat (254) begin
      add(TOK_BEGIN_NODE);
      add(name_word(1'b1));
    end
    add(TOK_PROP);
    add(32'd0);
    add($urandom);
    add(TOK_BEGIN_NODE);
    add($urandom, 1'b1);
  endfunction

  task send_beat(input struct_word_t sw, input bit typed, input fdt_event_t typed_ev);
    fdt_event_t ev;
    bit hit;
    while (!calm && $urandom_range(0, 99) < 33) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sw.word;
    in_tlast  <= sw.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (phase != WP_DONE) walk_items++;
    hit = walk_word(sw.word, sw.last, ev);
    if (typed) pending_events.push_back(typed_ev);
    else if (hit) pending_events.push_back(ev);
  endtask

  task flush_walk();
    while (walk_q.size() > 0) send_beat(walk_q.pop_front(), 1'b0, NO_EVENT);
  endtask

  task report(input string msg);
    fails++;
    if (fails <= 10) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= 33);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_ev = '{kind_t'(out_tuser), out_tdata[7:0], out_tdata[31:8],
                  out_tdata[63:32], out_tdata[95:64]};
      if (pending_events.size() == 0) begin
        report($sformatf("unexpected event kind %0d depth %0d content %0h ref %0h len %0h",
                         seen_ev.kind, seen_ev.depth, seen_ev.content, seen_ev.nref,
                         seen_ev.vlen));
      end else begin
        want_ev = pending_events.pop_front();
        if (seen_ev !== want_ev)
          report($sformatf({"expected kind %0d depth %0d content %0h ref %0h len %0h, ",
                            "got kind %0d depth %0d content %0h ref %0h len %0h"},
                           want_ev.kind, want_ev.depth, want_ev.content, want_ev.nref,
                           want_ev.vlen, seen_ev.kind, seen_ev.depth, seen_ev.content,
                           seen_ev.nref, seen_ev.vlen));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    dir_rows = '{
      '{TOK_NOP,        1'b0, 1'b0, NO_EVENT},
      '{TOK_BEGIN_NODE, 1'b0, 1'b0, NO_EVENT},
      '{32'h00FF_FFFF,  1'b0, 1'b1, '{KIND_NODE, 8'd0, 24'd3, 32'd2, 32'd0}},
      '{TOK_PROP,       1'b0, 1'b0, NO_EVENT},
      '{32'd0,          1'b0, 1'b0, NO_EVENT},
      '{32'd0,          1'b0, 1'b1, '{KIND_PROP, 8'd1, 24'd6, 32'd0, 32'd0}},
      '{TOK_PROP,       1'b0, 1'b0, NO_EVENT},
      '{32'd5,          1'b0, 1'b0, NO_EVENT},
      '{32'hFFFF_FFFF,  1'b0, 1'b1, '{KIND_PROP, 8'd1, 24'd9, 32'hFFFF_FFFF, 32'd5}},
      '{32'hFFFF_FFFF,  1'b0, 1'b0, NO_EVENT},
      '{32'd0,          1'b0, 1'b0, NO_EVENT},
      '{TOK_BEGIN_NODE, 1'b0, 1'b0, NO_EVENT},
      '{32'hFFFF_FFFF,  1'b0, 1'b0, NO_EVENT},
      '{32'h1122_3300,  1'b0, 1'b1, '{KIND_NODE, 8'd1, 24'd14, 32'd12, 32'd0}},
      '{TOK_NOP,        1'b0, 1'b0, NO_EVENT},
      '{TOK_END_NODE,   1'b0, 1'b0, NO_EVENT},
      '{TOK_END_NODE,   1'b0, 1'b0, NO_EVENT},
      '{TOK_END_NODE,   1'b0, 1'b1, '{KIND_FINISH, 8'd0, 24'd17, 32'd0, 32'd0}},
      '{32'h1234_5678,  1'b0, 1'b0, NO_EVENT},
      '{TOK_BEGIN_NODE, 1'b1, 1'b0, NO_EVENT},
      '{TOK_PROP,       1'b1, 1'b1, '{KIND_FINISH, 8'd0, 24'd0, 32'd0, 32'd0}},
      '{TOK_BEGIN_NODE, 1'b0, 1'b0, NO_EVENT},
      '{32'd0,          1'b0, 1'b1, '{KIND_NODE, 8'd0, 24'd2, 32'd1, 32'd0}},
      '{TOK_END,        1'b1, 1'b1, '{KIND_FINISH, 8'd1, 24'd2, 32'd0, 32'd0}},
      '{32'hFFFF_FFFF,  1'b1, 1'b1, '{KIND_FINISH, 8'd0, 24'd0, 32'd0, 32'd0}}
    };
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_beat('{dir_rows[i].word, dir_rows[i].last}, dir_rows[i].typed, dir_rows[i].ev);

    while (walk_items < ITEMS) begin
      if (!deep_done && walk_items >= 500) begin
        // hold off until the walker has drained
        in_tvalid <= 1'b0;
        while (pending_events.size() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        add_deep_walk();
        deep_done = 1'b1;
      end else if ($urandom_range(0, 99) < 85) begin
        gen_walk();
      end else begin
        add_noise();
      end
      calm = (walk_items >= 250) && (walk_items < 450);
      flush_walk();
    end

    in_tvalid <= 1'b0;
    calm = 1'b0;
    while (pending_events.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
+incdir+hdl
hdl/fdtw_pkg.sv
hdl/fdtw_front.sv
hdl/fdtw_queue.sv
hdl/fdtw_back.sv
hdl/fdt_structure_walker.sv
bench/tb_top.sv
